FILE: rtl/core/afp_pkg.sv
package afp_pkg;

  // tick counter and register widths
  localparam int TICK_W   = 48;
  localparam int REG_W    = 32;
  localparam int WIN_W    = 6;
  localparam int REQ_W    = 3;
  localparam int CFG_IDX_W = 3;

  // stream payload widths (data widths padded to whole bytes)
  localparam int S_DATA_W = 56;
  localparam int S_USER_W = REQ_W;
  localparam int M_DATA_W = 120;

  // output tdata bit positions
  localparam int M_WAIT_LSB     = 0;
  localparam int M_RESYNC_BIT   = TICK_W;
  localparam int M_MISSED_BIT   = TICK_W + 1;
  localparam int M_ADAPT_LSB    = TICK_W + 2;
  localparam int M_WORK_LSB     = M_ADAPT_LSB + REG_W;
  localparam int M_USED_W       = M_WORK_LSB + REG_W;

  // register reset values
  localparam logic [REG_W-1:0] FRAME_TICKS_RST   = 32'd166666;
  localparam logic [REG_W-1:0] BASE_PREP_RST     = 32'd10000;
  localparam logic [REG_W-1:0] ADAPT_CAP_RST     = 32'd80000;
  localparam logic [REG_W-1:0] QUARTER_MS_RST    = 32'd2500;
  localparam logic [WIN_W-1:0] WINDOW_FRAMES_RST = 6'd30;

  // event codes
  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN       = 3'd0,
    REQ_WORK_START  = 3'd1,
    REQ_FINISH      = 3'd2,
    REQ_REPHASE     = 3'd3,
    REQ_CLOCK_RESET = 3'd4
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_TICKS   = 3'd0,
    CFG_BASE_PREP     = 3'd1,
    CFG_ADAPT_CAP     = 3'd2,
    CFG_QUARTER_MS    = 3'd3,
    CFG_WINDOW_FRAMES = 3'd4
  } cfg_idx_t;

endpackage

FILE: rtl/core/adaptive_frame_pacer_top.sv
// channel   direction  ports                        payload
// s_*       in         s_tvalid s_tready s_tdata    event item: now, flags; kind in tuser
//                      s_tuser
// m_*       out        m_tvalid m_tready m_tdata    one result item per event item
// cfg_*     in         cfg_we cfg_addr cfg_wdata    register writes, no read-back
//
// one item per cycle while s_tready is high: each event is evaluated against the
// pacing state in one pass and its result is captured in the output register on the
// cycle it is accepted; s_tready is high while the output register is empty or
// being drained, so a result held back by the receiver stops the next item
// synchronous reset clears the pacing state and loads the register defaults
module adaptive_frame_pacer_top
  import afp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // [47:0] now_tick, [48] presented, [49] resync_after
  input  logic [S_DATA_W-1:0]  s_tdata,
  // [2:0] req_type
  input  logic [S_USER_W-1:0]  s_tuser,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [47:0] wait_until_tick, [48] clock_resynced, [49] deadline_missed,
  // [81:50] adaptive lead, [113:82] work_ticks
  output logic [M_DATA_W-1:0]  m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int EXT_W = TICK_W - REG_W;

  // configuration registers
  logic [REG_W-1:0] frame_ticks;
  logic [REG_W-1:0] base_prepare_ticks;
  logic [REG_W-1:0] adaptive_cap_ticks;
  logic [REG_W-1:0] quarter_ms_ticks;
  logic [WIN_W-1:0] window_frames;

  // pacing state
  logic              clock_valid, clock_valid_next;
  logic [TICK_W-1:0] next_present, next_present_next;
  logic              work_valid, work_valid_next;
  logic [TICK_W-1:0] work_start, work_start_next;
  logic [REG_W-1:0]  adaptive_prep, adaptive_prep_next;
  logic [REG_W-1:0]  window_max_work, window_max_work_next;
  logic [WIN_W-1:0]  window_count, window_count_next;

  // item fields
  logic [REQ_W-1:0]  req_type;
  logic [TICK_W-1:0] now_tick;
  logic              presented;
  logic              resync_after;
  logic              accept;

  // result fields
  logic [TICK_W-1:0] wait_tick;
  logic              resynced;
  logic              missed;
  logic [REG_W-1:0]  work_out;

  // datapath
  logic [TICK_W-1:0] frame_ext;
  logic [TICK_W-1:0] now_plus_frame;
  logic [TICK_W:0]   np_diff;
  logic              now_after_np;
  logic              late_frame;
  logic              late_quarter;
  logic              do_resync;
  logic [TICK_W-1:0] np_sel;
  logic [REG_W-1:0]  prep_max;
  logic [REG_W-1:0]  prep;
  logic [TICK_W-1:0] prep_ext;
  logic [TICK_W:0]   work_diff;
  logic [TICK_W-1:0] work;
  logic [REG_W-1:0]  work_sat;
  logic              work_qual;
  logic [REG_W-1:0]  wmax_upd;
  logic [WIN_W-1:0]  count_inc;
  logic              adapt_now;
  logic [REG_W:0]    desired_sum;
  logic [REG_W:0]    desired_lo;
  logic [REG_W-1:0]  desired;
  logic [REG_W+1:0]  lower_thr;
  logic [REG_W-1:0]  adapt_upd;

  assign req_type     = s_tuser[REQ_W-1:0];
  assign now_tick     = s_tdata[TICK_W-1:0];
  assign presented    = s_tdata[TICK_W];
  assign resync_after = s_tdata[TICK_W+1];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // target arithmetic shared by begin, finish and rephase
  assign frame_ext      = {{EXT_W{1'b0}}, frame_ticks};
  assign now_plus_frame = now_tick + frame_ext;
  assign np_diff        = {1'b0, now_tick} - {1'b0, next_present};
  assign now_after_np   = !np_diff[TICK_W];
  assign late_frame     = now_after_np &&
                          (np_diff[TICK_W-1:0] > frame_ext);
  assign late_quarter   = now_after_np &&
                          (np_diff[TICK_W-1:0] > {{EXT_W{1'b0}}, quarter_ms_ticks});

  // begin: resync decision and start tick
  assign do_resync = !clock_valid || late_frame;
  assign np_sel    = do_resync ? now_plus_frame : next_present;
  assign prep_max  = (adaptive_prep > base_prepare_ticks) ? adaptive_prep
                                                          : base_prepare_ticks;
  assign prep      = (prep_max > frame_ticks) ? frame_ticks : prep_max;
  assign prep_ext  = {{EXT_W{1'b0}}, prep};

  // finish: work time and window maximum
  assign work_diff = {1'b0, now_tick} - {1'b0, work_start};
  assign work      = work_diff[TICK_W] ? '0 : work_diff[TICK_W-1:0];
  assign work_sat  = (|work[TICK_W-1:REG_W]) ? '1 : work[REG_W-1:0];
  assign work_qual = (work <= {{EXT_W{1'b0}}, adaptive_cap_ticks}) &&
                     (work > {{EXT_W{1'b0}}, window_max_work});
  assign wmax_upd  = work_qual ? work[REG_W-1:0] : window_max_work;
  assign count_inc = window_count + WIN_W'(1);
  assign adapt_now = count_inc >= window_frames;

  // window end: raise at once or step down by a quarter millisecond
  assign desired_sum = {1'b0, wmax_upd} + {1'b0, quarter_ms_ticks};
  assign desired_lo  = (desired_sum < {1'b0, base_prepare_ticks}) ?
                       {1'b0, base_prepare_ticks} : desired_sum;
  assign desired     = (desired_lo > {1'b0, adaptive_cap_ticks}) ?
                       adaptive_cap_ticks : desired_lo[REG_W-1:0];
  assign lower_thr   = {2'b00, desired} + {1'b0, quarter_ms_ticks, 1'b0};

  always_comb begin
    if (desired > adaptive_prep) begin
      adapt_upd = desired;
    end else if ({2'b00, adaptive_prep} > lower_thr) begin
      adapt_upd = adaptive_prep - quarter_ms_ticks;
    end else begin
      adapt_upd = adaptive_prep;
    end
  end

  // per-event state update and result
  always_comb begin
    clock_valid_next     = clock_valid;
    next_present_next    = next_present;
    work_valid_next      = work_valid;
    work_start_next      = work_start;
    adaptive_prep_next   = adaptive_prep;
    window_max_work_next = window_max_work;
    window_count_next    = window_count;
    wait_tick            = '0;
    resynced             = 1'b0;
    missed               = 1'b0;
    work_out             = '0;
    case (req_type)
      REQ_BEGIN: begin
        next_present_next = np_sel;
        clock_valid_next  = 1'b1;
        resynced          = do_resync;
        wait_tick         = (np_sel > prep_ext) ? np_sel - prep_ext : '0;
      end
      REQ_WORK_START: begin
        work_start_next = now_tick;
        work_valid_next = 1'b1;
      end
      REQ_FINISH: begin
        if (presented && work_valid) begin
          work_out = work_sat;
          if (adapt_now) begin
            adaptive_prep_next   = adapt_upd;
            window_max_work_next = '0;
            window_count_next    = '0;
          end else begin
            window_max_work_next = wmax_upd;
            window_count_next    = count_inc;
          end
        end
        missed          = presented && !resync_after && late_quarter;
        work_valid_next = 1'b0;
        if (resync_after) begin
          clock_valid_next  = 1'b0;
          next_present_next = '0;
        end else begin
          next_present_next = next_present + frame_ext;
        end
      end
      REQ_REPHASE: begin
        next_present_next = now_plus_frame;
        clock_valid_next  = 1'b1;
      end
      REQ_CLOCK_RESET: begin
        clock_valid_next  = 1'b0;
        next_present_next = '0;
        work_valid_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks        <= FRAME_TICKS_RST;
      base_prepare_ticks <= BASE_PREP_RST;
      adaptive_cap_ticks <= ADAPT_CAP_RST;
      quarter_ms_ticks   <= QUARTER_MS_RST;
      window_frames      <= WINDOW_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_TICKS:   frame_ticks        <= cfg_wdata;
        CFG_BASE_PREP:     base_prepare_ticks <= cfg_wdata;
        CFG_ADAPT_CAP:     adaptive_cap_ticks <= cfg_wdata;
        CFG_QUARTER_MS:    quarter_ms_ticks   <= cfg_wdata;
        CFG_WINDOW_FRAMES: window_frames      <= cfg_wdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pacing state, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_valid     <= 1'b0;
      next_present    <= '0;
      work_valid      <= 1'b0;
      adaptive_prep   <= '0;
      window_max_work <= '0;
      window_count    <= '0;
    end else if (accept) begin
      clock_valid     <= clock_valid_next;
      next_present    <= next_present_next;
      work_valid      <= work_valid_next;
      adaptive_prep   <= adaptive_prep_next;
      window_max_work <= window_max_work_next;
      window_count    <= window_count_next;
    end
  end

  // start time is only read while work_valid is set
  always_ff @(posedge clk) begin
    if (accept) begin
      work_start <= work_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(M_DATA_W-M_USED_W){1'b0}}, work_out, adaptive_prep_next,
                  missed, resynced, wait_tick};
    end
  end

endmodule

FILE: rtl/core/afp_checker.sv
module afp_checker
  import afp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic [M_DATA_W-1:0]  m_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready
);

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out of reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // a resync comes only from begin, which never flags a miss or a work time
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_RESYNC_BIT] |->
      !m_tdata[M_MISSED_BIT] && (m_tdata[M_WORK_LSB +: REG_W] == '0))
    else $error("resync flagged on a non-begin result");

  // a miss comes only from finish, which gives no start tick
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_MISSED_BIT] |-> (m_tdata[M_WAIT_LSB +: TICK_W] == '0))
    else $error("miss flagged with a start tick");

endmodule

bind adaptive_frame_pacer_top afp_checker u_afp_checker (.*);

FILE: verif/afp_result_checker.sv
`timescale 1ns / 100ps

module afp_result_checker
  import afp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_DATA_W-1:0]  s_tdata,
  input  logic [S_USER_W-1:0]  s_tuser,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   checked,
  output int                   n_resynced,
  output int                   n_missed,
  output int                   n_raised,
  output int                   n_lowered
);

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [REG_W-1:0]  work_ticks;
    logic [REG_W-1:0]  prep_level;
    logic              deadline_missed;
    logic              clock_resynced;
    logic [TICK_W-1:0] wait_until_tick;
  } pacer_result_t;

  // register copies
  logic [REG_W-1:0]  frame_len;
  logic [REG_W-1:0]  base_prep;
  logic [REG_W-1:0]  cap_len;
  logic [REG_W-1:0]  quarter;
  logic [WIN_W-1:0]  win_len;

  // pacing state
  logic              clk_ok;
  logic [TICK_W-1:0] target;
  logic              work_on;
  logic [TICK_W-1:0] work_t0;
  logic [REG_W-1:0]  adapt_prep;
  logic [REG_W-1:0]  win_max;
  logic [WIN_W-1:0]  win_cnt;

  pacer_result_t     results_due[$];
  pacer_result_t     want;
  pacer_result_t     got;

  // true when a lies more than off beyond b
  function automatic logic past_by(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b,
                                   input logic [REG_W-1:0] off);
    return (a > b) && ((a - b) > off);
  endfunction

  function automatic void drop_clock();
    clk_ok  = 1'b0;
    target  = '0;
    work_on = 1'b0;
    work_t0 = '0;
  endfunction

  // next result of the pacer for one event item
  function automatic pacer_result_t pace_event(input logic [REQ_W-1:0] kind,
                                               input logic [TICK_W-1:0] now,
                                               input logic presented,
                                               input logic resync_after);
    pacer_result_t r;
    logic [63:0]   prep;
    logic [63:0]   work;
    logic [63:0]   desired;
    r = '0;
    case (kind)
      REQ_BEGIN: begin
        if (!clk_ok || past_by(now, target, frame_len)) begin
          target = now + frame_len;
          clk_ok = 1'b1;
          r.clock_resynced = 1'b1;
          n_resynced++;
        end
        prep = 64'(base_prep);
        if (adapt_prep > prep) prep = 64'(adapt_prep);
        if (prep > frame_len) prep = 64'(frame_len);
        r.wait_until_tick = (target > prep) ? TICK_W'(target - prep) : '0;
      end
      REQ_WORK_START: begin
        work_t0 = now;
        work_on = 1'b1;
      end
      REQ_FINISH: begin
        if (presented && work_on) begin
          work = (now > work_t0) ? 64'(now - work_t0) : 64'd0;
          r.work_ticks = (work > 64'hFFFF_FFFF) ? '1 : work[REG_W-1:0];
          if (work <= cap_len && work > win_max) win_max = work[REG_W-1:0];
          win_cnt = win_cnt + 6'd1;
          // end of window: raise at once, or step down slowly
          if (win_cnt >= win_len) begin
            desired = 64'(win_max) + 64'(quarter);
            if (desired < base_prep) desired = 64'(base_prep);
            if (desired > cap_len) desired = 64'(cap_len);
            if (desired > adapt_prep) begin
              adapt_prep = desired[REG_W-1:0];
              n_raised++;
            end else if (64'(adapt_prep) > desired + 2 * 64'(quarter)) begin
              adapt_prep = adapt_prep - quarter;
              n_lowered++;
            end
            win_max = '0;
            win_cnt = '0;
          end
        end
        if (presented && !resync_after && past_by(now, target, quarter)) begin
          r.deadline_missed = 1'b1;
          n_missed++;
        end
        work_on = 1'b0;
        work_t0 = '0;
        if (resync_after) drop_clock();
        else target = target + frame_len;
      end
      REQ_REPHASE: begin
        target = now + frame_len;
        clk_ok = 1'b1;
      end
      REQ_CLOCK_RESET: begin
        drop_clock();
      end
      default: begin
      end
    endcase
    r.prep_level = adapt_prep;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    if (errors < REPORT_LIMIT)
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $time, checked, what,
               got_v, want_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_len  = FRAME_TICKS_RST;
      base_prep  = BASE_PREP_RST;
      cap_len    = ADAPT_CAP_RST;
      quarter    = QUARTER_MS_RST;
      win_len    = WINDOW_FRAMES_RST;
      drop_clock();
      adapt_prep = '0;
      win_max    = '0;
      win_cnt    = '0;
      results_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_TICKS:   frame_len = cfg_wdata;
          CFG_BASE_PREP:     base_prep = cfg_wdata;
          CFG_ADAPT_CAP:     cap_len   = cfg_wdata;
          CFG_QUARTER_MS:    quarter   = cfg_wdata;
          CFG_WINDOW_FRAMES: win_len   = cfg_wdata[WIN_W-1:0];
          default: begin
          end
        endcase
      end
      // accepted event item
      if (s_tvalid && s_tready)
        results_due.push_back(pace_event(s_tuser, s_tdata[TICK_W-1:0], s_tdata[TICK_W],
                                         s_tdata[TICK_W+1]));
      // accepted result item
      if (m_tvalid && m_tready) begin
        got.wait_until_tick = m_tdata[M_WAIT_LSB +: TICK_W];
        got.clock_resynced  = m_tdata[M_RESYNC_BIT];
        got.deadline_missed = m_tdata[M_MISSED_BIT];
        got.prep_level      = m_tdata[M_ADAPT_LSB +: REG_W];
        got.work_ticks      = m_tdata[M_WORK_LSB +: REG_W];
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, wait_until_tick", 64'(got.wait_until_tick),
                          64'd0);
        end else begin
          want = results_due.pop_front();
          if (got.wait_until_tick !== want.wait_until_tick)
            report_mismatch("wait_until_tick", 64'(got.wait_until_tick),
                            64'(want.wait_until_tick));
          if (got.clock_resynced !== want.clock_resynced)
            report_mismatch("clock_resynced", 64'(got.clock_resynced),
                            64'(want.clock_resynced));
          if (got.deadline_missed !== want.deadline_missed)
            report_mismatch("deadline_missed", 64'(got.deadline_missed),
                            64'(want.deadline_missed));
          if (got.prep_level !== want.prep_level)
            report_mismatch("prep_level", 64'(got.prep_level), 64'(want.prep_level));
          if (got.work_ticks !== want.work_ticks)
            report_mismatch("work_ticks", 64'(got.work_ticks), 64'(want.work_ticks));
          checked++;
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

FILE: verif/adaptive_frame_pacer_top_tb.sv
`timescale 1ns / 100ps

module adaptive_frame_pacer_top_tb;
  import afp_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int PHASE_ITEMS      = 170;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 10;
  localparam int REQ_CODE_TOP     = (1 << REQ_W) - 1;
  localparam int REQ_SPARE_FIRST  = int'(REQ_CLOCK_RESET) + 1;
  localparam logic [TICK_W-1:0] TICK_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [S_USER_W-1:0]  s_tuser = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  int errors, pending, checked, n_resynced, n_missed, n_raised, n_lowered;
  int n_sent, n_settings, cycle_count;
  int tx_burst_left;
  int hold_left, rx_free_left, rx_roll;
  logic long_hold_done = 1'b0;

  // register values as last written, used to scale the stimulus
  logic [REG_W-1:0] frame_cfg   = FRAME_TICKS_RST;
  logic [REG_W-1:0] cap_cfg     = ADAPT_CAP_RST;
  logic [REG_W-1:0] quarter_cfg = QUARTER_MS_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_frame_pacer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  afp_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .n_resynced (n_resynced),
    .n_missed   (n_missed),
    .n_raised   (n_raised),
    .n_lowered  (n_lowered)
  );

  // result side: random stalls, stall-free stretches and one long hold-off
  always @(posedge clk) begin
    rx_roll = $urandom_range(0, 99);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES;
      m_tready       <= 1'b0;
    end else if (rx_free_left > 0) begin
      rx_free_left <= rx_free_left - 1;
      m_tready     <= 1'b1;
    end else if (rx_roll < 3) begin
      rx_free_left <= $urandom_range(20, 80);
      m_tready     <= 1'b1;
    end else if (rx_roll < 65) begin
      m_tready <= 1'b1;
    end else if (rx_roll < 95) begin
      hold_left <= $urandom_range(0, 3);
      m_tready  <= 1'b0;
    end else begin
      hold_left <= $urandom_range(8, 40);
      m_tready  <= 1'b0;
    end
  end

  // idle cycles before the next event item
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    if (roll < 2) begin
      tx_burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [63:0] rand_below(input logic [63:0] lim);
    return {$urandom, $urandom} % lim;
  endfunction

  task automatic send_event(input logic [REQ_W-1:0] kind, input logic [TICK_W-1:0] now,
                            input logic presented, input logic resync_after);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_DATA_W-TICK_W-2){1'b0}}, resync_after, presented, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  // stop offering and wait for every result to come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_FRAME_TICKS: frame_cfg   = value;
      CFG_ADAPT_CAP:   cap_cfg     = value;
      CFG_QUARTER_MS:  quarter_cfg = value;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] frame, input logic [REG_W-1:0] base,
                                input logic [REG_W-1:0] cap, input logic [REG_W-1:0] qms,
                                input logic [WIN_W-1:0] win);
    settle();
    write_reg(CFG_FRAME_TICKS, frame);
    write_reg(CFG_BASE_PREP, base);
    write_reg(CFG_ADAPT_CAP, cap);
    write_reg(CFG_QUARTER_MS, qms);
    write_reg(CFG_WINDOW_FRAMES, REG_W'(win));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // mostly well-formed frames on a rising clock, with some noise items
  task automatic run_phase(input int goal);
    logic [63:0]       t;
    logic [63:0]       span;
    logic [63:0]       dur;
    logic [REQ_W-1:0]  kind;
    int                pick;
    int                sel;
    t    = {$urandom_range(0, 32'h7FFF), $urandom};
    span = 64'(frame_cfg);
    while (n_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        t = t + rand_below(span / 4 + 1);
        send_event(REQ_BEGIN, t[TICK_W-1:0], 1'($urandom), 1'($urandom));
        t = t + rand_below(span / 2 + 1);
        if ($urandom_range(0, 19) != 0)
          send_event(REQ_WORK_START, t[TICK_W-1:0], 1'($urandom), 1'($urandom));
        sel = $urandom_range(0, 99);
        if (sel < 55) dur = rand_below(64'(cap_cfg) + 1);
        else if (sel < 85) dur = rand_below(2 * span + 1);
        else if (sel < 98) dur = rand_below(64'(cap_cfg) + 4 * 64'(quarter_cfg) + 1);
        else dur = rand_below(64'h3_0000_0000);
        t = t + dur;
        send_event(REQ_FINISH, t[TICK_W-1:0], $urandom_range(0, 19) != 0,
                   $urandom_range(0, 24) == 0);
      end else if (pick < 87) begin
        t = t + rand_below(span + 1);
        send_event(REQ_REPHASE, t[TICK_W-1:0], 1'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        send_event(REQ_CLOCK_RESET, t[TICK_W-1:0], 1'($urandom), 1'($urandom));
      end else begin
        // noise: any code, any tick, any flags
        kind = REQ_W'($urandom_range(0, REQ_CODE_TOP));
        send_event(kind, TICK_W'({$urandom, $urandom}), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items on the reset settings
    send_event(REQ_BEGIN, 48'd0, 1'b0, 1'b0);          // invalid clock, resync
    send_event(REQ_BEGIN, 48'd100, 1'b1, 1'b1);        // valid clock, no resync
    send_event(REQ_WORK_START, 48'd1000, 1'b0, 1'b0);
    send_event(REQ_FINISH, 48'd50000, 1'b1, 1'b0);     // measured, on time
    send_event(REQ_FINISH, 48'd60000, 1'b1, 1'b0);     // no work start, nothing measured
    send_event(REQ_WORK_START, 48'd400000, 1'b0, 1'b0);
    send_event(REQ_FINISH, 48'd300000, 1'b1, 1'b0);    // clock behind work start
    send_event(REQ_BEGIN, 48'd10000000, 1'b0, 1'b0);   // over a frame late, resync
    send_event(REQ_WORK_START, 48'd0, 1'b0, 1'b0);
    send_event(REQ_FINISH, 48'h100_0000_0000, 1'b1, 1'b0);  // saturated work, late
    send_event(REQ_WORK_START, 48'h100_0000_1000, 1'b0, 1'b0);
    send_event(REQ_FINISH, 48'h100_0000_2000, 1'b0, 1'b0);  // not presented
    send_event(REQ_FINISH, 48'h100_0000_3000, 1'b1, 1'b1);  // drop the clock
    send_event(REQ_FINISH, 48'd5000, 1'b1, 1'b0);      // invalid clock, stored target
    send_event(REQ_CLOCK_RESET, 48'd7, 1'b1, 1'b1);
    send_event(REQ_REPHASE, TICK_TOP - 48'd161666, 1'b0, 1'b0);  // target wraps low
    send_event(REQ_BEGIN, 48'd0, 1'b0, 1'b0);          // prepare above target
    send_event(REQ_REPHASE, TICK_TOP, 1'b1, 1'b0);
    send_event(REQ_BEGIN, TICK_TOP, 1'b0, 1'b1);
    for (int k = REQ_SPARE_FIRST; k <= REQ_CODE_TOP; k++)
      send_event(REQ_W'(k), TICK_TOP, 1'b1, 1'b1);     // unused codes
    send_event(REQ_WORK_START, TICK_TOP, 1'b0, 1'b0);
    send_event(REQ_FINISH, 48'd0, 1'b1, 1'b0);
    send_event(REQ_FINISH, TICK_TOP, 1'b1, 1'b0);

    // random phases over several register settings
    apply_settings(32'd1000, 32'd100, 32'd600, 32'd25, 6'd4);
    run_phase(n_sent + PHASE_ITEMS);
    apply_settings('1, '1, '1, '1, 6'd63);
    run_phase(n_sent + PHASE_ITEMS);
    apply_settings(32'd1, 32'd0, 32'd0, 32'd0, 6'd0);
    run_phase(n_sent + PHASE_ITEMS);
    apply_settings(FRAME_TICKS_RST, BASE_PREP_RST, ADAPT_CAP_RST, QUARTER_MS_RST, 6'd63);
    run_phase(n_sent + PHASE_ITEMS);
    // shorten the window part-way through
    settle();
    write_reg(CFG_WINDOW_FRAMES, REG_W'(1));
    cfg_we <= 1'b0;
    n_settings++;
    run_phase(n_sent + PHASE_ITEMS);
    apply_settings($urandom_range(1, 200000), $urandom_range(0, 40000),
                   $urandom_range(0, 150000), $urandom_range(0, 5000),
                   WIN_W'($urandom_range(1, 63)));
    run_phase(n_sent + PHASE_ITEMS);
    apply_settings(32'd50000, 32'd60000, 32'd40000, 32'd1000, 6'd2);
    run_phase(n_sent + PHASE_ITEMS);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d event items over %0d register settings, %0d results checked",
             n_sent, n_settings + 1, checked);
    $display("seen %0d resyncs, %0d late presents, prepare raised %0d and lowered %0d times",
             n_resynced, n_missed, n_raised, n_lowered);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
